>>> rtl/delimited_decimal_frame_parser_macros.svh
// ----------------------------------------------------------------------------
// delimited_decimal_frame_parser_macros.svh
// Assertion macros of the frame parser, used by ddfp_ctrl. All checks are
// clocked on aclk and are off while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef DELIMITED_DECIMAL_FRAME_PARSER_MACROS_SVH
`define DELIMITED_DECIMAL_FRAME_PARSER_MACROS_SVH

// Same-cycle implication: when ante holds, cons holds in that cycle.
`define DDFP_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("ddfp assertion failed");

// Next-cycle implication: when ante holds, cons holds in the following cycle.
`define DDFP_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("ddfp assertion failed");

`endif

>>> rtl/ddfp_pkg.sv
// ----------------------------------------------------------------------------
// ddfp_pkg
// Shared types and character codes of the delimited decimal frame parser.
// ----------------------------------------------------------------------------
package ddfp_pkg;

    // Delimiter and digit characters
    localparam logic [7:0] CH_OPEN  = 8'h23;  // '#'
    localparam logic [7:0] CH_CLOSE = 8'h24;  // '$'
    localparam logic [7:0] CH_SEP   = 8'h2C;  // ','
    localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'

    // Saturation limits of the digit counters
    localparam logic [6:0] TOTAL_MAX     = 7'd127;
    localparam logic [3:0] FIELD_CNT_MAX = 4'd15;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic open_frame;  // clear all counters for a new frame
        logic digit;       // take the input byte as a digit
        logic sep;         // field separator seen
        logic emit_start;  // point the emit index at field zero
        logic rd_en;       // read the field store at the emit index
        logic idx_step;    // advance the emit index
    } cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic is_open;     // input byte is the frame opener
        logic is_close;    // input byte is the frame closer
        logic is_sep;      // input byte is the field separator
        logic total_full;  // exactly FIELDS*DIGITS digits received
        logic field_ok;    // current field holds exactly DIGITS digits
        logic idx_last;    // emit index points at the final field
    } status_t;

endpackage

>>> rtl/ddfp_ctrl.sv
// ----------------------------------------------------------------------------
// ddfp_ctrl
// Frame state machine: classifies accepted bytes into commands for the
// datapath and sequences the emission of the stored field values.
// ----------------------------------------------------------------------------
`include "delimited_decimal_frame_parser_macros.svh"

module ddfp_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    input  ddfp_pkg::status_t status,
    output ddfp_pkg::cmd_t    cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RECV,
        ST_READ,
        ST_SHOW
    } state_t;

    state_t state_reg, state_next;
    logic   s_fire;
    logic   m_fire;

    // Handshake follows the state directly
    assign s_tready = (state_reg == ST_IDLE) || (state_reg == ST_RECV);
    assign m_tvalid = (state_reg == ST_SHOW);
    assign s_fire   = s_tvalid && s_tready;
    assign m_fire   = m_tvalid && m_tready;

    // Decode commands and next state
    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire && status.is_open) begin
                    cmd.open_frame = 1'b1;
                    state_next     = ST_RECV;
                end
            end
            ST_RECV: begin
                if (s_fire) begin
                    priority if (status.is_close) begin
                        if (status.total_full) begin
                            cmd.emit_start = 1'b1;
                            state_next     = ST_READ;
                        end
                    end else if (status.is_sep) begin
                        cmd.sep = 1'b1;
                        if (!status.field_ok) begin
                            state_next = ST_IDLE;
                        end
                    end else begin
                        cmd.digit = 1'b1;
                    end
                end
            end
            ST_READ: begin
                cmd.rd_en  = 1'b1;
                state_next = ST_SHOW;
            end
            ST_SHOW: begin
                if (m_fire) begin
                    if (status.idx_last) begin
                        state_next = ST_IDLE;
                    end else begin
                        cmd.idx_step = 1'b1;
                        state_next   = ST_READ;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Input and output sides never open together
    `DDFP_ASSERT_IMP(a_sides_exclusive, 1'b1, !(s_tready && m_tvalid))
    // A complete frame stops input until its fields are out
    `DDFP_ASSERT_NXT(a_close_stalls_input,
        s_fire && (state_reg == ST_RECV) && status.is_close && status.total_full,
        !s_tready && !m_tvalid)
    // Final field taken returns to listening
    `DDFP_ASSERT_NXT(a_last_returns_idle, m_fire && status.idx_last, s_tready)
    // Each non-final field taken is followed by a read of the field store
    `DDFP_ASSERT_NXT(a_read_between_fields, m_fire && !status.idx_last,
        !m_tvalid && !s_tready)

endmodule

>>> rtl/ddfp_datapath.sv
// ----------------------------------------------------------------------------
// ddfp_datapath
// Digit counters, weighted accumulation of each field, the field value
// store and the emit index.
// ----------------------------------------------------------------------------
module ddfp_datapath #(
    parameter int FIELDS = 4,
    parameter int DIGITS = 4
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_we,
    input  logic              cfg_wdata,
    input  logic [7:0]        s_byte,
    input  ddfp_pkg::cmd_t    cmd,
    output ddfp_pkg::status_t status,
    output logic [15:0]       value,
    output logic [3:0]        field_index
);

    localparam int TOTAL = FIELDS * DIGITS;
    localparam int PW    = (DIGITS > 1) ? $clog2(DIGITS) : 1;
    localparam int IW    = (FIELDS > 1) ? $clog2(FIELDS) : 1;

    logic          ascii_mode_reg;
    logic [6:0]    digit_total_reg;
    logic [3:0]    digits_in_field_reg;
    logic [PW-1:0] pos_reg;
    logic [IW-1:0] field_ptr_reg;
    logic [IW-1:0] idx_reg;
    logic [15:0]   acc_reg;
    logic [15:0]   acc_next;
    logic [15:0]   rd_data_reg;
    logic [15:0]   field_mem [FIELDS];

    logic [15:0]   digit_val;
    logic [15:0]   wt;
    logic [15:0]   term;
    logic          store;

    // Weight of a digit position: 10 to the power of the places after it
    function automatic logic [15:0] weight_of(input logic [PW-1:0] pos);
        logic [15:0] w;
        w = 16'd1;
        for (int e = 0; e < DIGITS; e++) begin
            if (e + 1 + int'(pos) < DIGITS) begin
                w = (w << 3) + (w << 1);
            end
        end
        return w;
    endfunction

    // Classify the input byte and report counter conditions
    always_comb begin
        status.is_open    = (s_byte == ddfp_pkg::CH_OPEN);
        status.is_close   = (s_byte == ddfp_pkg::CH_CLOSE);
        status.is_sep     = (s_byte == ddfp_pkg::CH_SEP);
        status.total_full = (digit_total_reg == 7'(TOTAL));
        status.field_ok   = (digits_in_field_reg == 4'(DIGITS));
        status.idx_last   = (idx_reg == IW'(FIELDS - 1));
    end

    // Weighted digit term, wrapped to 16 bits
    assign digit_val = ascii_mode_reg ? ({8'h00, s_byte} - {8'h00, ddfp_pkg::CH_ZERO})
                                      : {8'h00, s_byte};
    assign wt        = weight_of(pos_reg);
    assign term      = digit_val * wt;
    assign acc_next  = (pos_reg == '0) ? term : acc_reg + term;
    assign store     = cmd.digit && (digit_total_reg < 7'(TOTAL));

    // Hold the mode register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ascii_mode_reg <= 1'b1;
        end else if (cfg_we) begin
            ascii_mode_reg <= cfg_wdata;
        end
    end

    // Advance the digit counters, saturating past the limits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            digit_total_reg     <= '0;
            digits_in_field_reg <= '0;
        end else if (cmd.open_frame) begin
            digit_total_reg     <= '0;
            digits_in_field_reg <= '0;
        end else if (cmd.sep) begin
            digits_in_field_reg <= '0;
        end else if (cmd.digit) begin
            if (digit_total_reg < ddfp_pkg::TOTAL_MAX) begin
                digit_total_reg <= digit_total_reg + 7'd1;
            end
            if (digits_in_field_reg < ddfp_pkg::FIELD_CNT_MAX) begin
                digits_in_field_reg <= digits_in_field_reg + 4'd1;
            end
        end
    end

    // Track field and position of the next stored digit
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg       <= '0;
            field_ptr_reg <= '0;
        end else if (cmd.open_frame) begin
            pos_reg       <= '0;
            field_ptr_reg <= '0;
        end else if (store) begin
            if (pos_reg == PW'(DIGITS - 1)) begin
                pos_reg <= '0;
                if (field_ptr_reg != IW'(FIELDS - 1)) begin
                    field_ptr_reg <= field_ptr_reg + IW'(1);
                end
            end else begin
                pos_reg <= pos_reg + PW'(1);
            end
        end
    end

    // Accumulate the current field
    always_ff @(posedge aclk) begin
        if (store) begin
            acc_reg <= acc_next;
        end
    end

    // Field store: write on each digit below the frame total, registered read for emission
    always_ff @(posedge aclk) begin
        if (store) begin
            field_mem[field_ptr_reg] <= acc_next;
        end
        if (cmd.rd_en) begin
            rd_data_reg <= field_mem[idx_reg];
        end
    end

    // Step through the fields while emitting
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg <= '0;
        end else if (cmd.emit_start) begin
            idx_reg <= '0;
        end else if (cmd.idx_step) begin
            idx_reg <= idx_reg + IW'(1);
        end
    end

    assign value       = rd_data_reg;
    assign field_index = 4'(idx_reg);

endmodule

>>> rtl/delimited_decimal_frame_parser.sv
// ----------------------------------------------------------------------------
// delimited_decimal_frame_parser
// Parses '#'-opened, ','-separated, '$'-closed frames of decimal digits and
// streams out one 16-bit value per field.
// ----------------------------------------------------------------------------
// Every byte (opener, separator, closer, digit, or ignored byte) is accepted
// while s_tready is high. A closing '$' after exactly FIELDS*DIGITS digits
// stops input and emits FIELDS result transactions; each is read from the
// field store in ST_READ and then offered on the output in ST_SHOW until it
// is taken. No input is accepted while results are being emitted. The
// ascii_mode register (reset 1) subtracts '0' from each digit when set.
// ----------------------------------------------------------------------------
module delimited_decimal_frame_parser #(
    parameter int FIELDS = 4,
    parameter int DIGITS = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration: ascii_mode
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [15:0] value, [19:16] field_index, [23:20] zero
    output logic        m_tlast    // last field of the frame
);

    ddfp_pkg::cmd_t    cmd;
    ddfp_pkg::status_t status;
    logic [15:0]       value;
    logic [3:0]        field_index;

    // Frame controller
    ddfp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // Counters, accumulator and field store
    ddfp_datapath #(
        .FIELDS (FIELDS),
        .DIGITS (DIGITS)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .s_byte      (s_tdata),
        .cmd         (cmd),
        .status      (status),
        .value       (value),
        .field_index (field_index)
    );

    // Pack the result transaction
    assign m_tdata = {4'b0000, field_index, value};
    assign m_tlast = status.idx_last;

endmodule
